/* hdl/wrs_pkg.sv */
// Shared types and constants for the white region steering block.
`default_nettype none
package wrs_pkg;

  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned TOTAL_W  = 26;
  localparam int unsigned QUOT_W   = 16;
  localparam int unsigned WIDTH_W  = 13;
  localparam int unsigned LEVEL_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Number of channel bytes compared; only the first three exist.
  localparam int unsigned BYTES_PER_PIXEL = 3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL = 2'd1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [WIDTH_W-1:0] REGION_RESET = 13'd213;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET  = 8'd255;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN    = 13'd3;

  // floor(w / 3) == (w * 2731) >> 13 for every w up to 4096.
  localparam int unsigned RECIP_THIRD = 2731;
  localparam int unsigned RECIP_SHIFT = 13;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic signed [QUOT_W-1:0] TURN_MAX = 16'sd32767;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic       end_of_frame;
  } wrs_pixel_t;

  typedef struct packed {
    logic                     drive_forward;
    logic signed [QUOT_W-1:0] turn_rate;
    logic [COUNT_W-1:0]       white_total;
  } wrs_result_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] region;
    logic [LEVEL_W-1:0] level;
  } wrs_cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] right;
    logic [TOTAL_W-1:0] total;
  } wrs_frame_t;

endpackage
`default_nettype wire

/* hdl/wrs_front.sv */
// Pixel classifier with column counter and per-region white counters.
`default_nettype none
module wrs_front #(
  parameter int unsigned COL_W = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wrs_pkg::wrs_cfg_t  cfg,
  input  wire logic               in_valid,
  input  wire wrs_pkg::wrs_pixel_t in_data,
  output logic                    in_stall,
  input  wire logic               q_full,
  output logic                    push,
  output wrs_pkg::wrs_frame_t     push_frame
);
  import wrs_pkg::*;

  logic [COL_W-1:0]   column_r, column_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic [COUNT_W-1:0] middle_r, middle_nxt;
  logic [COUNT_W-1:0] right_r, right_nxt;
  logic               accept;
  logic               white;
  logic [7:0]         bytes [3];
  logic [COL_W:0]     col_inc;
  logic [WIDTH_W:0]   twice_region;
  logic [COUNT_W-1:0] left_upd, middle_upd, right_upd;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    bytes[0] = in_data.byte_first;
    bytes[1] = in_data.byte_second;
    bytes[2] = in_data.byte_third;
    white = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (i < BYTES_PER_PIXEL && bytes[i] != cfg.level) begin
        white = 1'b0;
      end
    end
  end

  always_comb begin
    twice_region = {cfg.region, 1'b0};
    left_upd   = left_r;
    middle_upd = middle_r;
    right_upd  = right_r;
    if (white) begin
      if (WIDTH_W'(column_r) < cfg.region) begin
        if (left_r != COUNT_MAX) left_upd = left_r + 1'b1;
      end else if ((WIDTH_W + 1)'(column_r) < twice_region) begin
        if (middle_r != COUNT_MAX) middle_upd = middle_r + 1'b1;
      end else begin
        if (right_r != COUNT_MAX) right_upd = right_r + 1'b1;
      end
    end
    col_inc = {1'b0, column_r} + 1'b1;
  end

  always_comb begin
    column_nxt = column_r;
    left_nxt   = left_r;
    middle_nxt = middle_r;
    right_nxt  = right_r;
    push       = 1'b0;
    push_frame.left  = left_upd;
    push_frame.right = right_upd;
    push_frame.total = TOTAL_W'(left_upd) + TOTAL_W'(middle_upd) + TOTAL_W'(right_upd);
    if (accept) begin
      if (in_data.end_of_frame) begin
        push       = 1'b1;
        column_nxt = '0;
        left_nxt   = '0;
        middle_nxt = '0;
        right_nxt  = '0;
      end else begin
        left_nxt   = left_upd;
        middle_nxt = middle_upd;
        right_nxt  = right_upd;
        if ((WIDTH_W + 1)'(col_inc) >= {1'b0, cfg.width}) begin
          column_nxt = '0;
        end else begin
          column_nxt = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      left_r   <= '0;
      middle_r <= '0;
      right_r  <= '0;
    end else begin
      column_r <= column_nxt;
      left_r   <= left_nxt;
      middle_r <= middle_nxt;
      right_r  <= right_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/wrs_queue.sv */
// Short queue of finished frame counts between the classifier and the divider.
`default_nettype none
module wrs_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire wrs_pkg::wrs_frame_t push_frame,
  input  wire logic                pop,
  output logic                     full,
  output logic                     not_empty,
  output wrs_pkg::wrs_frame_t      head
);
  import wrs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  wrs_frame_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_frame;
    end
  end

endmodule
`default_nettype wire

/* hdl/wrs_back.sv */
// Bit-serial turn rate divider and result output register.
`default_nettype none
module wrs_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire wrs_pkg::wrs_frame_t q_head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wrs_pkg::wrs_result_t     out_data
);
  import wrs_pkg::*;

  localparam int unsigned REM_W  = TOTAL_W + 1;
  localparam int unsigned STEP_W = $clog2(QUOT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [QUOT_W-1:0]   quot_r, quot_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  wrs_result_t         out_data_r, out_data_nxt;
  logic                ge;
  logic [REM_W-1:0]    rem_sub;
  wrs_result_t         result;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ge      = (rem_r >= {1'b0, total_r});
    rem_sub = ge ? rem_r - {1'b0, total_r} : rem_r;
  end

  always_comb begin
    result.drive_forward = (total_r != '0);
    result.white_total   = (total_r > TOTAL_W'(COUNT_MAX)) ? COUNT_MAX : total_r[COUNT_W-1:0];
    if (total_r == '0) begin
      result.turn_rate = '0;
    end else if (neg_r) begin
      result.turn_rate = -$signed(quot_r);
    end else if (quot_r[QUOT_W-1]) begin
      result.turn_rate = TURN_MAX;
    end else begin
      result.turn_rate = $signed(quot_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    total_nxt     = total_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          pop       = 1'b1;
          total_nxt = q_head.total;
          neg_nxt   = (q_head.left < q_head.right);
          rem_nxt   = (q_head.left < q_head.right) ?
                      REM_W'(q_head.right - q_head.left) :
                      REM_W'(q_head.left - q_head.right);
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        quot_nxt = {quot_r[QUOT_W-2:0], ge};
        rem_nxt  = {rem_sub[REM_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    total_r    <= total_nxt;
    quot_r     <= quot_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* hdl/white_region_steering.sv */
// Top level of the white region steering block: configuration, front, queue and back.
// Pixels are taken one per cycle; in_stall rises only while the frame queue is full.
// After its end_of_frame pixel is accepted, a frame's counts pass the queue, the 16-step
// serial divider and output register; the next frame pops after the last result registers.
// Short frames that outpace the back fill the two-entry queue and stall the pixel input.
// Synchronous active-low reset clears the counters, the queue and the output valid,
// and returns image_width to 640 and white_level to 255.
`default_nettype none
module white_region_steering #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire wrs_pkg::wrs_pixel_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output wrs_pkg::wrs_result_t                     out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [wrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [wrs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import wrs_pkg::*;

  // The column counter only has to hold values below the widest allowed row.
  localparam int unsigned COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

  // Configuration is held already clamped, with the region width precomputed,
  // so the pixel path sees only compares.
  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic [WIDTH_W-1:0] region_r, region_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [WIDTH_W-1:0] eff_width;
  logic [24:0]        third_prod;
  wrs_cfg_t           cfg;

  logic               q_push, q_pop, q_full, q_not_empty;
  wrs_frame_t         push_frame, q_head;

  // Writes are never refused.
  assign cfg_ready = 1'b1;

  // Clamp the written width into the legal range, then divide by three with a
  // reciprocal multiply that is exact over that range.
  always_comb begin
    if (cfg_wdata < WIDTH_MIN) begin
      eff_width = WIDTH_MIN;
    end else if (cfg_wdata > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = cfg_wdata;
    end
    third_prod = 25'(eff_width) * 25'(RECIP_THIRD);
  end

  always_comb begin
    width_nxt  = width_r;
    region_nxt = region_r;
    level_nxt  = level_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_nxt  = eff_width;
          region_nxt = WIDTH_W'(third_prod >> RECIP_SHIFT);
        end
        CFG_WHITE_LEVEL: begin
          level_nxt = cfg_wdata[LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      region_r <= REGION_RESET;
      level_r  <= LEVEL_RESET;
    end else begin
      width_r  <= width_nxt;
      region_r <= region_nxt;
      level_r  <= level_nxt;
    end
  end

  assign cfg.width  = width_r;
  assign cfg.region = region_r;
  assign cfg.level  = level_r;

  // Front: classifies each pixel and accumulates the three region counts.
  wrs_front #(
    .COL_W (COL_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (q_push),
    .push_frame (push_frame)
  );

  // Queue: holds finished frame counts while the divider is busy.
  wrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (push_frame),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back: forms the turn rate one quotient bit per cycle and holds the result.
  wrs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // A frame is never written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame pushed into a full queue");

  // The divider only takes a frame that is actually queued.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("frame popped from an empty queue");

  // A result with no white pixels must stop and carry no turn and a zero white total.
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.drive_forward) |->
      (out_data.turn_rate == '0 && out_data.white_total == '0))
    else $error("empty frame produced a nonzero turn or total");

  // Forward drive agrees with the reported white count.
  a_drive_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drive_forward == (out_data.white_total != '0)))
    else $error("drive_forward disagrees with white_total");

endmodule
`default_nettype wire
